### src/lps_pkg.sv
// Package for the latency path selector: codes, constants, types and the blend function.
package lps_pkg;

    localparam int LAT_W = 17;
    localparam int CNT_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [LAT_W-1:0] LAT_MAX = {LAT_W{1'b1}};
    localparam logic [LAT_W-1:0] LAT_RESET = 17'd16000;
    localparam logic [CNT_W-1:0] PROBE_RESET = 8'd10;
    localparam logic [LAT_W-1:0] PENALTY_RESET = 17'd64000;
    localparam logic [7:0] BLEND_NUM = 8'd77;

    localparam logic [1:0] PMODE_AUTO = 2'd0;
    localparam logic [1:0] PMODE_PATH0 = 2'd1;
    localparam logic [1:0] PMODE_PATH1 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PATH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY = 2'd2;

    localparam logic REQ_CHOOSE = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ACT_SEND  = 2'd0,
        ACT_RETRY = 2'd1,
        ACT_DONE  = 2'd2
    } t_action;

    typedef struct packed {
        logic             path;
        t_action          action;
        logic [LAT_W-1:0] avg0;
        logic [LAT_W-1:0] avg1;
    } t_result;

    function automatic logic [LAT_W-1:0] blend(input logic [LAT_W-1:0] old_v,
                                               input logic [LAT_W-1:0] x);
        logic signed [LAT_W:0]   diff;
        logic signed [LAT_W+8:0] prod;
        logic signed [LAT_W+8:0] adj;
        logic signed [LAT_W+1:0] q;
        logic signed [LAT_W+1:0] sum;
        diff = $signed({1'b0, x}) - $signed({1'b0, old_v});
        prod = diff * $signed({1'b0, BLEND_NUM});
        adj  = prod[LAT_W+8] ? prod + (LAT_W+9)'(255) : prod;
        q    = {adj[LAT_W+8], adj[LAT_W+8:8]};
        sum  = $signed({2'b00, old_v}) + q;
        if (sum[LAT_W+1]) begin
            blend = '0;
        end else if (sum[LAT_W]) begin
            blend = LAT_MAX;
        end else begin
            blend = sum[LAT_W-1:0];
        end
    endfunction

endpackage

### src/lps_req_if.sv
// Request channel of the latency path selector: valid, ready and the input item fields.
interface lps_req_if
    import lps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             mode;
    logic             attempt_ok;
    logic [LAT_W-1:0] measured_latency;

    modport source (output valid, output mode, output attempt_ok,
                    output measured_latency, input ready);
    modport sink (input valid, input mode, input attempt_ok,
                  input measured_latency, output ready);
endinterface

### src/lps_res_if.sv
// Result channel of the latency path selector: valid, ready and the result item fields.
interface lps_res_if
    import lps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             path;
    logic [1:0]       action;
    logic [LAT_W-1:0] avg_path0;
    logic [LAT_W-1:0] avg_path1;

    modport source (output valid, output path, output action, output avg_path0,
                    output avg_path1, input ready);
    modport sink (input valid, input path, input action, input avg_path0,
                  input avg_path1, output ready);
endinterface

### src/latency_path_selector_unit.sv
// Top level of the latency path selector: path choice, latency learning and result buffer.
//
// Usage:
// - i_req carries items: mode 0 asks for a path for a new sample, mode 1
//   reports the outcome (attempt_ok, measured_latency) of the pending attempt.
// - o_res returns exactly one item per request item: the path, the action
//   (send, retry, sample finished) and both smoothed latencies after the item.
// - The config port (i_cfg_we, i_cfg_idx, i_cfg_wdata) writes path_mode,
//   probe_period and failure_penalty; write only while no item is in flight.
// - Results are registered: output register, or skid register while the output one waits.
// - Throughput: one item per cycle while ready is high; the state update and path
//   choice are short combinational logic between the accept edge and the result register.
// - A two-entry result buffer (output register plus skid register) lets an
//   item be accepted while a result waits; ready drops only when both are full
//   and rises again once the receiver takes a result.
// - Reset: synchronous, active low. Averages go to 1000 ms, paths untried,
//   probe count cleared, registers to auto mode, period 10, penalty 4000 ms.
module latency_path_selector_unit
    import lps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lps_req_if.sink               i_req,
    lps_res_if.source             o_res
);

    logic [1:0]       r_path_mode;
    logic [CNT_W-1:0] r_probe_period;
    logic [LAT_W-1:0] r_penalty;

    logic [LAT_W-1:0] r_avg0, r_avg1, n_avg0, n_avg1;
    logic             r_tried0, r_tried1, n_tried0, n_tried1;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pend_path, n_pend_path;
    logic             r_pend_retry, n_pend_retry;

    t_result          r_out, r_skid, n_res;
    logic             r_out_vld, r_skid_vld;

    logic             acc, out_take, sel_auto, p1_faster, probe;
    logic [CNT_W-1:0] cnt_inc;
    logic [LAT_W-1:0] blend_in, blend_out;

    assign acc       = i_req.valid && i_req.ready;
    assign out_take  = r_out_vld && o_res.ready;
    assign sel_auto  = (r_path_mode != PMODE_PATH0) && (r_path_mode != PMODE_PATH1);
    assign p1_faster = r_avg1 <= r_avg0;
    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign probe     = cnt_inc >= r_probe_period;
    assign blend_in  = r_pend_path ? r_avg1 : r_avg0;
    assign blend_out = blend(blend_in, i_req.measured_latency);

    always_comb begin
        n_avg0       = r_avg0;
        n_avg1       = r_avg1;
        n_tried0     = r_tried0;
        n_tried1     = r_tried1;
        n_cnt        = r_cnt;
        n_pend_path  = r_pend_path;
        n_pend_retry = 1'b0;
        n_res.path   = r_pend_path;
        n_res.action = ACT_DONE;
        if (i_req.mode == REQ_CHOOSE) begin
            n_res.action = ACT_SEND;
            priority if (r_path_mode == PMODE_PATH0) begin
                n_res.path = 1'b0;
            end else if (r_path_mode == PMODE_PATH1) begin
                n_res.path = 1'b1;
            end else if (!r_tried0) begin
                n_res.path = 1'b0;
            end else if (!r_tried1) begin
                n_res.path = 1'b1;
            end else begin
                n_cnt      = probe ? '0 : cnt_inc;
                n_res.path = probe ? !p1_faster : p1_faster;
            end
            n_pend_path = n_res.path;
        end else if (i_req.attempt_ok) begin
            if (r_pend_path) begin
                n_avg1   = blend_out;
                n_tried1 = 1'b1;
            end else begin
                n_avg0   = blend_out;
                n_tried0 = 1'b1;
            end
        end else if (sel_auto && !r_pend_retry) begin
            if (r_pend_path) begin
                n_avg1   = r_penalty;
                n_tried1 = 1'b1;
            end else begin
                n_avg0   = r_penalty;
                n_tried0 = 1'b1;
            end
            n_pend_path  = !r_pend_path;
            n_pend_retry = 1'b1;
            n_res.path   = !r_pend_path;
            n_res.action = ACT_RETRY;
        end
        n_res.avg0 = n_avg0;
        n_res.avg1 = n_avg1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_mode    <= PMODE_AUTO;
            r_probe_period <= PROBE_RESET;
            r_penalty      <= PENALTY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_PATH_MODE) begin
                r_path_mode <= i_cfg_wdata[1:0];
            end
            if (i_cfg_idx == REG_PROBE_PERIOD) begin
                r_probe_period <= i_cfg_wdata[CNT_W-1:0];
            end
            if (i_cfg_idx == REG_PENALTY) begin
                r_penalty <= i_cfg_wdata[LAT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg0       <= LAT_RESET;
            r_avg1       <= LAT_RESET;
            r_tried0     <= 1'b0;
            r_tried1     <= 1'b0;
            r_cnt        <= '0;
            r_pend_path  <= 1'b0;
            r_pend_retry <= 1'b0;
        end else if (acc) begin
            r_avg0       <= n_avg0;
            r_avg1       <= n_avg1;
            r_tried0     <= n_tried0;
            r_tried1     <= n_tried1;
            r_cnt        <= n_cnt;
            r_pend_path  <= n_pend_path;
            r_pend_retry <= n_pend_retry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (acc) begin
            if (r_out_vld && !o_res.ready) begin
                r_skid_vld <= 1'b1;
            end
            r_out_vld <= 1'b1;
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (acc) begin
            if (r_out_vld && !o_res.ready) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign i_req.ready     = !r_skid_vld;
    assign o_res.valid     = r_out_vld;
    assign o_res.path      = r_out.path;
    assign o_res.action    = r_out.action;
    assign o_res.avg_path0 = r_out.avg0;
    assign o_res.avg_path1 = r_out.avg1;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without output entry");

    a_success_marks_tried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.mode == REQ_REPORT && i_req.attempt_ok) |=> (r_tried0 || r_tried1))
        else $error("successful report left both paths untried");

    a_retry_from_failure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pend_retry) |-> $past(acc && i_req.mode == REQ_REPORT && !i_req.attempt_ok))
        else $error("retry pending without a failure report");

    a_accept_fills_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_vld)
        else $error("accepted item produced no result");

endmodule
